### rtl/cbm_pkg.sv
// shared types and constants of the cartridge bank mapper
`default_nettype none

package cbm_pkg;

  localparam int unsigned BUS_AW = 16;
  localparam int unsigned ROM_AW = 21;
  localparam int unsigned DATA_W = 8;

  // mapper selection; the fourth code behaves as rom only
  typedef enum logic [1:0] {
    MAP_ROM_ONLY = 2'd0,
    MAP_MBC1     = 2'd1,
    MAP_MBC3     = 2'd2,
    MAP_ROM_ALT  = 2'd3
  } map_type_e;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // bus address regions, selected by address bits 15:13
  localparam logic [2:0] RGN_RAM_EN   = 3'd0;
  localparam logic [2:0] RGN_ROM_BANK = 3'd1;
  localparam logic [2:0] RGN_RAM_BANK = 3'd2;
  localparam logic [2:0] RGN_MODE     = 3'd3;
  localparam logic [2:0] RGN_ERAM     = 3'd5;

  localparam logic [DATA_W-1:0] OPEN_BUS = 8'hFF;

  typedef struct packed {
    logic              op;
    logic [BUS_AW-1:0] bus_address;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic              rom_fetch;
    logic [ROM_AW-1:0] rom_address;
    logic [DATA_W-1:0] read_data;
  } rsp_t;

  // decoded transaction waiting for its ram read data
  typedef struct packed {
    logic              ram_read;
    logic              rom_fetch;
    logic [ROM_AW-1:0] rom_address;
    logic [DATA_W-1:0] read_data;
  } stg_t;

endpackage

`default_nettype wire

### rtl/cbm_ram.sv
// generic single-clock ram with one write port and one registered read port
`default_nettype none

module cbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32768
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/cbm_decode.sv
// bank registers, mapper type register and bus access decode
`default_nettype none

module cbm_decode import cbm_pkg::*; #(
  parameter int unsigned ERAM_BYTES    = 32768,
  parameter int unsigned ROM_ADDR_BITS = 21
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [1:0]                    cfg_data_i,
  input  wire logic                          accept_i,
  input  wire req_t                          req_i,
  output stg_t                               stg_o,
  output logic                               ram_we_o,
  output logic                               ram_re_o,
  output logic [$clog2(ERAM_BYTES)-1:0]      ram_addr_o,
  output logic [DATA_W-1:0]                  ram_wdata_o
);

  localparam int unsigned RamAw = $clog2(ERAM_BYTES);
  localparam logic [ROM_AW-1:0] RomMask = ROM_AW'((64'd1 << ROM_ADDR_BITS) - 64'd1);
  localparam logic [16:0] Eram1 = 17'(ERAM_BYTES);
  localparam logic [16:0] Eram2 = 17'(2 * ERAM_BYTES);

  map_type_e mapper_type_q;
  logic [6:0] rom_bank_q, rom_bank_d;
  logic [1:0] ram_bank_q, ram_bank_d;
  logic       mode_q, mode_d;
  logic       ram_en_q, ram_en_d;

  map_type_e          typ;
  logic               is_rom, is_mbc1, wr, in_ram;
  logic [2:0]         region;
  logic [1:0]         ram_bank_eff;
  logic [16:0]        idx0, idx1, idx2;
  logic [6:0]         bank7, romb_new;
  logic [ROM_AW-1:0]  raw_addr;

  always_comb begin
    typ     = (mapper_type_q == MAP_ROM_ALT) ? MAP_ROM_ONLY : mapper_type_q;
    is_rom  = (typ == MAP_ROM_ONLY);
    is_mbc1 = (typ == MAP_MBC1);
    region  = req_i.bus_address[15:13];
    in_ram  = (region == RGN_ERAM);
    wr      = accept_i && (req_i.op == OP_WRITE) && !is_rom;

    // ram byte index, wrapped to the ram size (value stays below four sizes)
    ram_bank_eff = (is_mbc1 && !mode_q) ? 2'd0 : ram_bank_q;
    idx0 = {2'b00, ram_bank_eff, req_i.bus_address[12:0]};
    idx1 = (idx0 >= Eram2) ? (idx0 - Eram2) : idx0;
    idx2 = (idx1 >= Eram1) ? (idx1 - Eram1) : idx1;

    // switchable rom window bank
    if (is_mbc1) begin
      bank7 = {(mode_q ? 2'b00 : ram_bank_q), rom_bank_q[4:0]};
    end else begin
      bank7 = rom_bank_q;
    end

    stg_o    = '0;
    raw_addr = '0;
    if (req_i.op == OP_READ) begin
      if (req_i.bus_address[15:14] == 2'b00 || (is_rom && !req_i.bus_address[15])) begin
        stg_o.rom_fetch = 1'b1;
        raw_addr        = {5'b00000, req_i.bus_address};
      end else if (!req_i.bus_address[15]) begin
        stg_o.rom_fetch = 1'b1;
        raw_addr        = {bank7, req_i.bus_address[13:0]};
      end else if (!is_rom && in_ram && ram_en_q) begin
        stg_o.ram_read = 1'b1;
      end else begin
        stg_o.read_data = OPEN_BUS;
      end
    end
    stg_o.rom_address = raw_addr & RomMask;

    romb_new = req_i.write_data[6:0] & (is_mbc1 ? 7'h1F : 7'h7F);
  end

  // control register updates
  always_comb begin
    rom_bank_d = rom_bank_q;
    ram_bank_d = ram_bank_q;
    mode_d     = mode_q;
    ram_en_d   = ram_en_q;
    if (wr) begin
      unique case (region)
        RGN_RAM_EN:   ram_en_d = (req_i.write_data[3:0] == 4'hA);
        RGN_ROM_BANK: rom_bank_d = (romb_new == 7'd0) ? 7'd1 : romb_new;
        RGN_RAM_BANK: begin
          if (req_i.write_data[7:2] == 6'd0) begin
            ram_bank_d = req_i.write_data[1:0];
          end
        end
        RGN_MODE: begin
          if (is_mbc1) begin
            mode_d = req_i.write_data[0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mapper_type_q <= MAP_ROM_ONLY;
      rom_bank_q    <= 7'd1;
      ram_bank_q    <= 2'd0;
      mode_q        <= 1'b0;
      ram_en_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mapper_type_q <= map_type_e'(cfg_data_i);
      end
      rom_bank_q <= rom_bank_d;
      ram_bank_q <= ram_bank_d;
      mode_q     <= mode_d;
      ram_en_q   <= ram_en_d;
    end
  end

  assign ram_we_o    = wr && in_ram && ram_en_q;
  assign ram_re_o    = accept_i && stg_o.ram_read;
  assign ram_addr_o  = idx2[RamAw-1:0];
  assign ram_wdata_o = req_i.write_data;

  // zero rom bank is always remapped to one
  assert property (@(posedge clk_i) disable iff (!rst_ni) rom_bank_q != 7'd0)
    else $error("rom bank register holds zero");

  // a ram read is only decoded when the ram is enabled on a banked mapper
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_o.ram_read |-> ram_en_q && !is_rom)
    else $error("ram read decoded while ram is not accessible");

endmodule

`default_nettype wire

### rtl/cbm_out.sv
// ram read stage and output register
`default_nettype none

module cbm_out import cbm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire stg_t              stg_i,
  input  wire logic [DATA_W-1:0] ram_rdata_i,
  input  wire logic              out_ready_i,
  output logic                   s1_ready_o,
  output logic                   out_valid_o,
  output rsp_t                   out_data_o
);

  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic move;
  stg_t s1_q;
  rsp_t out_data_q;

  assign move       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign s1_ready_o = !s1_valid_q || move;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (load_i) begin
      s1_valid_d = 1'b1;
    end else if (move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_q <= stg_i;
    end
    if (move) begin
      out_data_q.rom_fetch   <= s1_q.rom_fetch;
      out_data_q.rom_address <= s1_q.rom_address;
      out_data_q.read_data   <= s1_q.ram_read ? ram_rdata_i : s1_q.read_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a transaction moved out of the read stage shows up at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni) move |=> out_valid_q)
    else $error("read stage advanced without filling the output register");

  // a blocked read stage keeps its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !move |=> s1_valid_q && $stable(s1_q))
    else $error("read stage overwritten while blocked");

endmodule

`default_nettype wire

### rtl/cartridge_bank_mapper_core.sv
// top level of the cartridge bank mapper
//
//  port group   dir  handshake               payload
//  cfg          in   cfg_valid_i/cfg_ready_o  cfg_data_i (mapper type)
//  in           in   in_valid_i/in_ready_o    in_data_i  (req_t bus access)
//  out          out  out_valid_o/out_ready_i  out_data_o (rsp_t result)
//
// one bus access per cycle while in_ready_o is high; an accepted access goes
// to the read stage (decode with ram read), then the output register
// ram reads and writes go to the external ram at acceptance, so a read right
// after a write to the same byte sees the new byte
// after reset the external ram is filled with 0xff, one byte per cycle, over
// all ERAM_BYTES bytes; no bus access is taken during that pass
// a stalled output holds one result and one more in the read stage
`default_nettype none

module cartridge_bank_mapper_core import cbm_pkg::*; #(
  parameter int unsigned ERAM_BYTES    = 32768,
  parameter int unsigned ROM_ADDR_BITS = 21
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire req_t       in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output rsp_t            out_data_o
);

  localparam int unsigned RamAw = $clog2(ERAM_BYTES);
  localparam logic [RamAw-1:0] LastIdx = RamAw'(ERAM_BYTES - 1);

  logic              clearing_q, clearing_d;
  logic [RamAw-1:0]  clr_q, clr_d;
  logic              accept, s1_ready;
  stg_t              stg;
  logic              dec_we, dec_re;
  logic [RamAw-1:0]  dec_addr;
  logic [DATA_W-1:0] dec_wdata, ram_rdata;
  logic              ram_we;
  logic [RamAw-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !clearing_q && s1_ready;
  assign accept      = in_valid_i && in_ready_o;

  // clearing pass over the external ram
  always_comb begin
    clearing_d = clearing_q;
    clr_d      = clr_q;
    if (clearing_q) begin
      clr_d = clr_q + RamAw'(1);
      if (clr_q == LastIdx) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_q      <= clr_d;
    end
  end

  cbm_decode #(
    .ERAM_BYTES   (ERAM_BYTES),
    .ROM_ADDR_BITS(ROM_ADDR_BITS)
  ) u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .req_i      (in_data_i),
    .stg_o      (stg),
    .ram_we_o   (dec_we),
    .ram_re_o   (dec_re),
    .ram_addr_o (dec_addr),
    .ram_wdata_o(dec_wdata)
  );

  assign ram_we    = clearing_q || dec_we;
  assign ram_waddr = clearing_q ? clr_q : dec_addr;
  assign ram_wdata = clearing_q ? OPEN_BUS : dec_wdata;

  cbm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(ERAM_BYTES)
  ) u_eram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (dec_re),
    .raddr_i(dec_addr),
    .rdata_o(ram_rdata)
  );

  cbm_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .stg_i      (stg),
    .ram_rdata_i(ram_rdata),
    .out_ready_i(out_ready_i),
    .s1_ready_o (s1_ready),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

  // the clearing pass runs once after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni) !clearing_q |=> !clearing_q)
    else $error("ram clearing pass restarted");

endmodule

`default_nettype wire

### tb/tb_cartridge_bank_mapper_core.sv
// self-checking testbench for the cartridge bank mapper core
`default_nettype none

module tb_cartridge_bank_mapper_core import cbm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ERAM_BYTES  = 32768;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // shadow copy of the mapper registers and external ram, plus the replies still due
  class bank_shadow;
    map_type_e   mapper;
    logic [6:0]  rom_bank;
    logic [1:0]  ram_bank;
    logic        bank_mode;
    logic        ram_on;
    logic [7:0]  eram [ERAM_BYTES];
    rsp_t        due [$];
    int unsigned errors;

    function new();
      mapper    = MAP_ROM_ONLY;
      rom_bank  = 7'd1;
      ram_bank  = 2'd0;
      bank_mode = 1'b0;
      ram_on    = 1'b0;
      errors    = 0;
      foreach (eram[i]) eram[i] = OPEN_BUS;
    endfunction

    function void set_mapper(map_type_e t);
      mapper = t;
    endfunction

    function logic [14:0] eram_index(map_type_e kind, logic [15:0] addr);
      logic [1:0] bank;
      bank = (kind == MAP_MBC1 && !bank_mode) ? 2'd0 : ram_bank;
      return {bank, addr[12:0]};
    endfunction

    // apply one accepted bus transaction and queue the reply it must produce
    function void note_access(req_t a);
      map_type_e         kind;
      rsp_t              exp;
      logic [6:0]        bank;
      logic [6:0]        sel;
      logic [15:0]       addr;
      logic [7:0]        d;
      logic              in_eram;
      kind    = (mapper == MAP_ROM_ALT) ? MAP_ROM_ONLY : mapper;
      addr    = a.bus_address;
      d       = a.write_data;
      in_eram = addr[15:13] == RGN_ERAM;
      exp     = '0;
      if (a.op == OP_READ) begin
        if (addr <= 16'h3FFF || (kind == MAP_ROM_ONLY && addr <= 16'h7FFF)) begin
          exp.rom_fetch   = 1'b1;
          exp.rom_address = ROM_AW'(addr);
        end else if (addr <= 16'h7FFF) begin
          if (kind == MAP_MBC1) bank = {bank_mode ? 2'd0 : ram_bank, rom_bank[4:0]};
          else bank = rom_bank;
          exp.rom_fetch   = 1'b1;
          exp.rom_address = {bank, addr[13:0]};
        end else if (kind != MAP_ROM_ONLY && in_eram && ram_on) begin
          exp.read_data = eram[eram_index(kind, addr)];
        end else begin
          exp.read_data = OPEN_BUS;
        end
      end else if (kind != MAP_ROM_ONLY) begin
        unique case (addr[15:13])
          RGN_RAM_EN: ram_on = d[3:0] == 4'hA;
          RGN_ROM_BANK: begin
            sel = (kind == MAP_MBC1) ? {2'b00, d[4:0]} : d[6:0];
            rom_bank = (sel == 7'd0) ? 7'd1 : sel;
          end
          RGN_RAM_BANK: if (d <= 8'd3) ram_bank = d[1:0];
          RGN_MODE: if (kind == MAP_MBC1) bank_mode = d[0];
          RGN_ERAM: if (ram_on) eram[eram_index(kind, addr)] = d;
          default: ;
        endcase
      end
      due.push_back(exp);
    endfunction

    function void check_reply(rsp_t got);
      rsp_t exp;
      if (due.size() == 0) begin
        $display("%0t: reply with none due, got %h", $time, got);
        errors++;
        return;
      end
      exp = due.pop_front();
      if (got.rom_fetch !== exp.rom_fetch) begin
        $display("%0t: rom_fetch expected %0b actual %0b", $time, exp.rom_fetch, got.rom_fetch);
        errors++;
      end
      if (got.rom_address !== exp.rom_address) begin
        $display("%0t: rom_address expected %h actual %h", $time, exp.rom_address,
                 got.rom_address);
        errors++;
      end
      if (got.read_data !== exp.read_data) begin
        $display("%0t: read_data expected %h actual %h", $time, exp.read_data, got.read_data);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  req_t       in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  rsp_t       out_data_o;

  bank_shadow  shadow;
  logic        steady;
  int unsigned cycles;

  cartridge_bank_mapper_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one, none during steady stretches
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (steady || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) shadow.check_reply(out_data_o);
  end

  initial begin
    int n;
    int g;
    forever begin
      n = $urandom_range(1, 12);
      out_ready_i <= 1'b1;
      repeat (n) @(posedge clk_i);
      g = pick_gap();
      if (g > 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  function automatic req_t access(logic op, logic [15:0] addr, logic [7:0] d);
    req_t r;
    r.op          = op;
    r.bus_address = addr;
    r.write_data  = d;
    return r;
  endfunction

  function automatic logic [15:0] eram_address();
    unique case ($urandom_range(0, 2))
      0: return 16'hA000 + 16'($urandom_range(0, 7));
      1: return 16'hBFF8 + 16'($urandom_range(0, 7));
      default: return 16'($urandom_range(16'hA000, 16'hBFFF));
    endcase
  endfunction

  // weighted toward control writes and banked accesses, with some raw noise
  function automatic req_t random_access();
    req_t r;
    int   pick;
    pick          = $urandom_range(0, 99);
    r.op          = OP_WRITE;
    r.bus_address = 16'($urandom);
    r.write_data  = 8'($urandom);
    if (pick < 10) begin
      r.op = 1'($urandom);
    end else if (pick < 20) begin
      r.bus_address = 16'($urandom_range(16'h0000, 16'h1FFF));
      if ($urandom_range(0, 9) < 7) r.write_data[3:0] = 4'hA;
    end else if (pick < 28) begin
      r.bus_address = 16'($urandom_range(16'h2000, 16'h3FFF));
      if ($urandom_range(0, 4) == 0) r.write_data[4:0] = 5'd0;
    end else if (pick < 36) begin
      r.bus_address = 16'($urandom_range(16'h4000, 16'h5FFF));
      if ($urandom_range(0, 4) != 0) r.write_data = 8'($urandom_range(0, 3));
    end else if (pick < 41) begin
      r.bus_address = 16'($urandom_range(16'h6000, 16'h7FFF));
    end else if (pick < 58) begin
      r.bus_address = eram_address();
    end else if (pick < 78) begin
      r.op          = OP_READ;
      r.bus_address = eram_address();
    end else if (pick < 95) begin
      r.op          = OP_READ;
      r.bus_address = 16'($urandom_range(16'h0000, 16'h7FFF));
    end else begin
      r.op          = OP_READ;
      r.bus_address = $urandom_range(0, 1) ? 16'($urandom_range(16'h8000, 16'h9FFF))
                                           : 16'($urandom_range(16'hC000, 16'hFFFF));
    end
    return r;
  endfunction

  task automatic send_access(req_t a);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= a;
    do @(posedge clk_i); while (!in_ready_o);
    shadow.note_access(a);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (shadow.due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mapper(map_type_e t);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= t;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow.set_mapper(t);
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      steady = (i % 60) >= 45;
      send_access(random_access());
    end
    steady = 1'b0;
  endtask

  initial begin
    req_t mbc1_seq [$];
    req_t mbc3_seq [$];
    shadow      = new();
    steady      = 1'b0;
    cycles      = 0;
    rst_ni      = 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= MAP_ROM_ONLY;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    mbc1_seq = '{
      access(OP_READ,  16'h0000, 8'h00), access(OP_READ,  16'h3FFF, 8'hFF),
      access(OP_READ,  16'h4000, 8'h00), access(OP_READ,  16'hA000, 8'h00),
      access(OP_WRITE, 16'h0000, 8'h0A), access(OP_WRITE, 16'hA000, 8'h00),
      access(OP_READ,  16'hA000, 8'hFF), access(OP_WRITE, 16'hBFFF, 8'h5A),
      access(OP_WRITE, 16'h3FFF, 8'hE0), access(OP_READ,  16'h4000, 8'h00),
      access(OP_WRITE, 16'h2000, 8'h1F), access(OP_WRITE, 16'h4000, 8'h03),
      access(OP_READ,  16'h7FFF, 8'h00), access(OP_WRITE, 16'h5FFF, 8'h04),
      access(OP_WRITE, 16'h4000, 8'hFF), access(OP_WRITE, 16'h6000, 8'h01),
      access(OP_READ,  16'hBFFF, 8'h00), access(OP_WRITE, 16'h7FFF, 8'h00),
      access(OP_READ,  16'hBFFF, 8'h00), access(OP_WRITE, 16'h1FFF, 8'h1B),
      access(OP_READ,  16'hA000, 8'h00), access(OP_READ,  16'h8000, 8'h00),
      access(OP_READ,  16'hFFFF, 8'h00), access(OP_WRITE, 16'hC000, 8'h12)
    };
    mbc3_seq = '{
      access(OP_WRITE, 16'h2000, 8'h80), access(OP_READ,  16'h4000, 8'h00),
      access(OP_WRITE, 16'h3FFF, 8'h7F), access(OP_WRITE, 16'h6000, 8'h01),
      access(OP_READ,  16'h7FFF, 8'h00)
    };

    write_mapper(MAP_ROM_ONLY);
    send_random(60);

    write_mapper(MAP_MBC1);
    foreach (mbc1_seq[i]) send_access(mbc1_seq[i]);
    send_random(110);

    write_mapper(MAP_MBC3);
    foreach (mbc3_seq[i]) send_access(mbc3_seq[i]);
    send_random(110);

    write_mapper(MAP_ROM_ALT);
    send_random(40);

    write_mapper(MAP_MBC1);
    send_random(80);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (shadow.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
